// ===== design/ethb_pkg.sv =====
// Shared constants, codes and interface types of the event time histogram binner.
`timescale 1ns / 1ps
`default_nettype none

package ethb_pkg;

   // default sizes
   localparam int DEF_NUM_BINS  = 1024;
   localparam int DEF_TIME_BITS = 48;

   // fixed field widths
   localparam int BIN_INDEX_W = 10;
   localparam int COUNT_W     = 32;
   localparam int WIDTH_W     = 32;
   localparam int ENERGY_W    = 20;
   localparam int CHANNEL_W   = 16;
   localparam int EBOUND_W    = 21;
   localparam int CBOUND_W    = 17;
   localparam int CSR_INDEX_W = 3;

   // action codes
   localparam logic [1:0] ACT_COUNT = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_START_TIME   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LEN   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BIN_WIDTH    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ENERGY_LOW   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ENERGY_HIGH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_LOW  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_HIGH = 3'd6;

   // bin RAM access strobes
   typedef struct packed {
      logic rd;
      logic wr;
   } ram_cmd_type;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== design/event_time_histogram_binner_top.sv =====
// Event time histogram binner top level: sequencer, config registers, result register.
// Flow to rsp_valid: count subtracts, checks windows, divides bit-serially, then a RAM RMW;
// a time or window reject or a bin past the latched count skips the RAM; read does a RAM read;
// clear divides window_length, then sweeps RAM one bin per cycle; unused action: zero result.
// Throughput: one request at a time; the next is taken in the cycle after the result is loaded.
// Reset (synchronous, active high) loads register defaults and runs a RAM sweep over every bin.
`timescale 1ns / 1ps
`default_nettype none

module event_time_histogram_binner_top #(
   parameter int NUM_BINS  = ethb_pkg::DEF_NUM_BINS,
   parameter int TIME_BITS = ethb_pkg::DEF_TIME_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // configuration
   input  wire logic                                 csr_wr_en,
   input  wire logic [ethb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [TIME_BITS-1:0]                 csr_wdata,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_action,
   input  wire logic [TIME_BITS-1:0]                 req_event_time,
   input  wire logic [ethb_pkg::ENERGY_W-1:0]        req_event_energy,
   input  wire logic [ethb_pkg::CHANNEL_W-1:0]       req_event_channel,
   input  wire logic [ethb_pkg::BIN_INDEX_W-1:0]     req_read_index,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_event_counted,
   output logic      [ethb_pkg::BIN_INDEX_W-1:0]     rsp_bin_index,
   output logic      [ethb_pkg::COUNT_W-1:0]         rsp_bin_count
);
   import ethb_pkg::*;

   localparam int ADDR_W = $clog2(NUM_BINS);
   localparam int USE_W  = $clog2(NUM_BINS + 1);
   localparam int IDX_W  = (ADDR_W > BIN_INDEX_W) ? ADDR_W : BIN_INDEX_W;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_CLEAR  = 8'b0000_0010,
      S_SUB    = 8'b0000_0100,
      S_CHECK  = 8'b0000_1000,
      S_DIV    = 8'b0001_0000,
      S_READ   = 8'b0010_0000,
      S_MODIFY = 8'b0100_0000,
      S_FINISH = 8'b1000_0000
   } state_type;

   // control state
   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   sweep_ff, sweep_in;
   logic                clr_reply_ff, clr_reply_in;   // sweep came from a clear request
   logic [USE_W-1:0]    bins_use_ff, bins_use_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // configuration registers
   logic [TIME_BITS-1:0] start_ff;
   logic [TIME_BITS-1:0] length_ff;
   logic [WIDTH_W-1:0]   width_ff;
   logic [EBOUND_W-1:0]  elo_ff, ehi_ff;
   logic [CBOUND_W-1:0]  clo_ff, chi_ff;

   // request payload and working registers
   logic [1:0]             act_ff, act_in;
   logic [TIME_BITS-1:0]   time_ff, time_in;
   logic [ENERGY_W-1:0]    energy_ff, energy_in;
   logic [CHANNEL_W-1:0]   channel_ff, channel_in;
   logic [TIME_BITS-1:0]   diff_ff, diff_in;
   logic                   early_ff, early_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic                   pend_counted_ff, pend_counted_in;
   logic [BIN_INDEX_W-1:0] pend_index_ff, pend_index_in;
   logic [COUNT_W-1:0]     pend_count_ff, pend_count_in;
   logic                   rsp_counted_ff, rsp_counted_in;
   logic [BIN_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [COUNT_W-1:0]     rsp_count_ff, rsp_count_in;

   // unit hookups
   ram_cmd_type          ram_cmd;
   logic [ADDR_W-1:0]    ram_addr;
   logic [COUNT_W-1:0]   ram_wdata;
   logic [COUNT_W-1:0]   ram_rdata;
   logic                 div_start;
   logic [TIME_BITS-1:0] div_dividend;
   div_status_type       div_status;
   logic [TIME_BITS-1:0] div_quotient;

   // combinational helpers
   logic [WIDTH_W-1:0]     eff_width;
   logic [TIME_BITS:0]     sub_full;
   logic signed [21:0]     e_val, e_lo, e_hi;
   logic signed [17:0]     c_val, c_lo, c_hi;
   logic                   e_reject, c_reject, t_reject;
   logic [IDX_W-1:0]       ridx_wide;
   logic                   ridx_ok;
   logic [COUNT_W-1:0]     count_inc;

   // a bin width of zero behaves as one
   assign eff_width = (width_ff == '0) ? WIDTH_W'(1) : width_ff;
   assign sub_full  = {1'b0, time_ff} - {1'b0, start_ff};

   // windows: disabled when both bounds are negative; high bound inclusive
   assign e_val    = signed'({2'b00, energy_ff});
   assign e_lo     = signed'({elo_ff[EBOUND_W-1], elo_ff});
   assign e_hi     = signed'({ehi_ff[EBOUND_W-1], ehi_ff});
   assign e_reject = !(elo_ff[EBOUND_W-1] && ehi_ff[EBOUND_W-1]) &&
                     ((e_val < e_lo) || (e_val > e_hi));
   assign c_val    = signed'({2'b00, channel_ff});
   assign c_lo     = signed'({clo_ff[CBOUND_W-1], clo_ff});
   assign c_hi     = signed'({chi_ff[CBOUND_W-1], chi_ff});
   assign c_reject = !(clo_ff[CBOUND_W-1] && chi_ff[CBOUND_W-1]) &&
                     ((c_val < c_lo) || (c_val > c_hi));
   // event at exactly start + length is still inside
   assign t_reject = early_ff || (diff_ff > length_ff);

   assign ridx_wide = IDX_W'(req_read_index);
   assign ridx_ok   = 32'(req_read_index) < 32'(NUM_BINS);

   // saturating increment of the fetched count
   assign count_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_W'(1);

   ethb_divider #(
      .TIME_BITS (TIME_BITS)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .start      (div_start),
      .dividend   (div_dividend),
      .divisor    (eff_width),
      .div_status (div_status),
      .quotient   (div_quotient)
   );

   ethb_bin_ram #(
      .NUM_BINS (NUM_BINS)
   ) u_bin_ram (
      .clock     (clock),
      .ram_cmd   (ram_cmd),
      .ram_addr  (ram_addr),
      .ram_wdata (ram_wdata),
      .ram_rdata (ram_rdata)
   );

   // sequencer
   always_comb begin
      state_in        = state_ff;
      sweep_in        = sweep_ff;
      clr_reply_in    = clr_reply_ff;
      bins_use_in     = bins_use_ff;
      act_in          = act_ff;
      time_in         = time_ff;
      energy_in       = energy_ff;
      channel_in      = channel_ff;
      diff_in         = diff_ff;
      early_in        = early_ff;
      addr_in         = addr_ff;
      pend_counted_in = pend_counted_ff;
      pend_index_in   = pend_index_ff;
      pend_count_in   = pend_count_ff;
      rsp_counted_in  = rsp_counted_ff;
      rsp_index_in    = rsp_index_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      ram_cmd         = '0;
      ram_addr        = addr_ff;
      ram_wdata       = '0;
      div_start       = 1'b0;
      div_dividend    = diff_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in     = req_action;
               time_in    = req_event_time;
               energy_in  = req_event_energy;
               channel_in = req_event_channel;
               // default result: all zero (drop, clear, unused action)
               pend_counted_in = 1'b0;
               pend_index_in   = '0;
               pend_count_in   = '0;
               case (req_action)
                  ACT_COUNT: begin
                     state_in = S_SUB;
                  end
                  ACT_READ: begin
                     pend_index_in = req_read_index;
                     if (ridx_ok) begin
                        addr_in  = ridx_wide[ADDR_W-1:0];
                        state_in = S_READ;
                     end else begin
                        state_in = S_FINISH;
                     end
                  end
                  ACT_CLEAR: begin
                     div_start    = 1'b1;
                     div_dividend = length_ff;
                     state_in     = S_DIV;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            ram_cmd.wr = 1'b1;
            ram_addr   = sweep_ff;
            sweep_in   = sweep_ff + ADDR_W'(1);
            if (sweep_ff == ADDR_W'(NUM_BINS - 1)) begin
               clr_reply_in = 1'b0;
               state_in     = clr_reply_ff ? S_FINISH : S_IDLE;
            end
         end
         S_SUB: begin
            diff_in  = sub_full[TIME_BITS-1:0];
            early_in = sub_full[TIME_BITS];
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (t_reject || e_reject || c_reject) begin
               state_in = S_FINISH;
            end else begin
               div_start    = 1'b1;
               div_dividend = diff_ff;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            if (div_status.done) begin
               if (act_ff == ACT_CLEAR) begin
                  bins_use_in  = (div_quotient > TIME_BITS'(NUM_BINS)) ?
                                 USE_W'(NUM_BINS) : div_quotient[USE_W-1:0];
                  sweep_in     = '0;
                  clr_reply_in = 1'b1;
                  state_in     = S_CLEAR;
               end else if (div_quotient < TIME_BITS'(bins_use_ff)) begin
                  addr_in       = div_quotient[ADDR_W-1:0];
                  pend_index_in = div_quotient[BIN_INDEX_W-1:0];
                  state_in      = S_READ;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_READ: begin
            ram_cmd.rd = 1'b1;
            state_in   = S_MODIFY;
         end
         S_MODIFY: begin
            if (act_ff == ACT_COUNT) begin
               ram_cmd.wr      = 1'b1;
               ram_wdata       = count_inc;
               pend_counted_in = 1'b1;
               pend_count_in   = count_inc;
            end else begin
               pend_count_in = ram_rdata;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            // hand over once the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in   = 1'b1;
               rsp_counted_in = pend_counted_ff;
               rsp_index_in   = pend_index_ff;
               rsp_count_in   = pend_count_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         clr_reply_ff <= 1'b0;
         bins_use_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_reply_ff <= clr_reply_in;
         bins_use_ff  <= bins_use_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // configuration registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         length_ff <= '0;
         width_ff  <= WIDTH_W'(1);
         elo_ff    <= '1;
         ehi_ff    <= '1;
         clo_ff    <= '1;
         chi_ff    <= '1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_START_TIME:   start_ff  <= csr_wdata;
            REG_WINDOW_LEN:   length_ff <= csr_wdata;
            REG_BIN_WIDTH:    width_ff  <= csr_wdata[WIDTH_W-1:0];
            REG_ENERGY_LOW:   elo_ff    <= csr_wdata[EBOUND_W-1:0];
            REG_ENERGY_HIGH:  ehi_ff    <= csr_wdata[EBOUND_W-1:0];
            REG_CHANNEL_LOW:  clo_ff    <= csr_wdata[CBOUND_W-1:0];
            REG_CHANNEL_HIGH: chi_ff    <= csr_wdata[CBOUND_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff          <= act_in;
      time_ff         <= time_in;
      energy_ff       <= energy_in;
      channel_ff      <= channel_in;
      diff_ff         <= diff_in;
      early_ff        <= early_in;
      addr_ff         <= addr_in;
      pend_counted_ff <= pend_counted_in;
      pend_index_ff   <= pend_index_in;
      pend_count_ff   <= pend_count_in;
      rsp_counted_ff  <= rsp_counted_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_counted = rsp_counted_ff;
   assign rsp_bin_index     = rsp_index_ff;
   assign rsp_bin_count     = rsp_count_ff;

   // a counted event never reports an empty bin
   a_counted_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_counted_ff) |-> (rsp_count_ff != '0))
      else $error("counted event reports zero bin count");

   // latched bin count never exceeds the RAM depth
   a_bins_in_range: assert property (@(posedge clock) disable iff (reset)
      bins_use_ff <= USE_W'(NUM_BINS))
      else $error("bins in use beyond RAM depth");

   // single-port RAM: no read and write in one cycle
   a_ram_one_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_cmd.rd && ram_cmd.wr))
      else $error("bin RAM read and write collide");

   // divider only runs while the sequencer waits on it
   a_div_owned: assert property (@(posedge clock) disable iff (reset)
      (div_status.busy || div_status.done) |-> (state_ff == S_DIV))
      else $error("divider active outside divide state");

   // an accepted request always takes the sequencer out of idle
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff != S_IDLE))
      else $error("accepted request left sequencer idle");

endmodule

`default_nettype wire

// ===== design/ethb_divider.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, shared by binning and clear.
`timescale 1ns / 1ps
`default_nettype none

module ethb_divider #(
   parameter int TIME_BITS = ethb_pkg::DEF_TIME_BITS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [TIME_BITS-1:0]           dividend,
   input  wire logic [ethb_pkg::WIDTH_W-1:0]   divisor,
   output ethb_pkg::div_status_type            div_status,
   output logic      [TIME_BITS-1:0]           quotient
);
   import ethb_pkg::*;

   localparam int CNT_W = $clog2(TIME_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [WIDTH_W-1:0]   rem_ff, rem_in;
   logic [WIDTH_W-1:0]   div_ff, div_in;
   logic [TIME_BITS-1:0] quo_ff, quo_in;
   logic [WIDTH_W:0]     trial;
   logic [WIDTH_W:0]     trial_sub;
   logic                 fits;

   assign trial     = {rem_ff, quo_ff[TIME_BITS-1]};
   assign trial_sub = trial - {1'b0, div_ff};
   assign fits      = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(TIME_BITS);
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so 32 bits hold it
         rem_in = fits ? trial_sub[WIDTH_W-1:0] : trial[WIDTH_W-1:0];
         quo_in = {quo_ff[TIME_BITS-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign div_status.busy = busy_ff;
   assign div_status.done = done_ff;
   assign quotient        = quo_ff;

endmodule

`default_nettype wire

// ===== design/ethb_bin_ram.sv =====
// Single-port bin count RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ethb_bin_ram #(
   parameter int NUM_BINS = ethb_pkg::DEF_NUM_BINS
) (
   input  wire logic                              clock,
   input  wire ethb_pkg::ram_cmd_type             ram_cmd,
   input  wire logic [$clog2(NUM_BINS)-1:0]       ram_addr,
   input  wire logic [ethb_pkg::COUNT_W-1:0]      ram_wdata,
   output logic      [ethb_pkg::COUNT_W-1:0]      ram_rdata
);
   import ethb_pkg::*;

   logic [COUNT_W-1:0] mem [NUM_BINS];
   logic [COUNT_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ram_cmd.wr) begin
         mem[ram_addr] <= ram_wdata;
      end
      if (ram_cmd.rd) begin
         rdata_ff <= mem[ram_addr];
      end
   end

   assign ram_rdata = rdata_ff;

endmodule

`default_nettype wire
